>>> rtl/core/spe_pkg.sv
// spe_pkg: types and constants for the shortest path engine.
// No dependencies. Used by shortest_path_engine_unit.
`default_nettype none
package spe_pkg;

  localparam int VTX_W  = 7;
  localparam int DIST_W = 22;
  localparam int CNT_W  = 13;
  localparam int WIN_W  = 16;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic [VTX_W-1:0]  VCOUNT_RESET   = 7'd64;
  localparam logic [DIST_W-1:0] DIST_INF       = 22'h3FFFFF;
  localparam logic [DIST_W-1:0] DIST_MAX_REACH = 22'h3FFFFE;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = 13'h1FFF;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD_DIR   = 2'd1,
    OP_ADD_UNDIR = 2'd2,
    OP_RUN       = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_INIT,
    ST_SEL,
    ST_MARK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic [WIN_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic              has_predecessor;
    logic [VTX_W-1:0]  predecessor;
    logic [CNT_W-1:0]  relax_count;
    logic              last;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/shortest_path_engine_unit.sv
// Edge add writes the edge store on acceptance; undirected also writes the reverse in ST_EDGE2.
// Clear sweeps all 2^(2*ceil(log2 MAX_VERTICES)) edge store entries. Run from source over n
// vertices: an init pass through the vertex store, then per settled vertex a select scan, one
// mark step and a relax scan; then each result is read, registered and held until taken.
// Reset: sweeps the edge store clear (4096 entries at 64 vertices), in_stall high.
// shortest_path_engine_unit: top level, edge store and vertex store. Uses spe_pkg.
`default_nettype none
module shortest_path_engine_unit
  import spe_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [VTX_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item
);

  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int EADDR_W = 2 * VIDX_W;
  localparam int EDEPTH  = 1 << EADDR_W;
  localparam int STAMP_W = $clog2(MAX_VERTICES * MAX_VERTICES + 2);
  localparam int SUM_W   = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
  localparam int IDX_W   = VTX_W + 1;

  typedef struct packed {
    logic [DIST_W-1:0]  cost;
    logic [VTX_W-1:0]   pred;
    logic               visited;
    logic [STAMP_W-1:0] stamp;
  } vrec_t;

  // memories
  logic [WEIGHT_BITS:0] edge_mem [EDEPTH];
  vrec_t                vtx_mem  [MAX_VERTICES];

  logic                 e_we;
  logic [EADDR_W-1:0]   e_waddr, e_raddr;
  logic [WEIGHT_BITS:0] e_wdata, e_rdata;
  logic                 v_we;
  logic [VIDX_W-1:0]    v_waddr, v_raddr;
  vrec_t                v_wdata, v_rdata;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vtx_mem[v_waddr] <= v_wdata;
    end
    v_rdata <= vtx_mem[v_raddr];
  end

  // registers
  state_t             state, state_next;
  logic [VTX_W-1:0]   vertex_count;
  logic [EADDR_W-1:0] clr_cnt;
  in_item_t           item;
  logic [VTX_W-1:0]   n_run;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   pv;
  logic               pvalid;
  logic               best_found;
  logic [VTX_W-1:0]   best_v;
  vrec_t              best_rec;
  logic [STAMP_W-1:0] stamp_ctr;
  logic [CNT_W-1:0]   relax_cnt;

  // combinational helpers
  logic               accept;
  logic [VTX_W-1:0]   n_act;
  logic               edge_ok;
  logic [WEIGHT_BITS-1:0] w_in, w_item;
  logic               issue;
  logic               scan_done;
  logic               src_ok;
  logic               sel_better;
  logic [SUM_W-1:0]   cand_full;
  logic [DIST_W-1:0]  cand;
  logic               relax_ok;
  logic               out_hp;

  assign accept = in_valid && !in_stall;
  assign w_in   = WEIGHT_BITS'(in_item.edge_weight);
  assign w_item = WEIGHT_BITS'(item.edge_weight);

  always_comb begin
    if (vertex_count == '0) begin
      n_act = VTX_W'(1);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_act = VTX_W'(MAX_VERTICES);
    end else begin
      n_act = vertex_count;
    end
  end

  assign edge_ok = (in_item.from_vertex != '0) && (in_item.to_vertex != '0) &&
                   (32'(in_item.from_vertex) <= 32'(MAX_VERTICES)) &&
                   (32'(in_item.to_vertex) <= 32'(MAX_VERTICES));

  assign src_ok    = (item.from_vertex != '0) && (item.from_vertex <= n_run);
  assign issue     = (idx <= {1'b0, n_run});
  assign scan_done = !issue && !pvalid;

  assign sel_better = !v_rdata.visited && (v_rdata.cost != DIST_INF) &&
                      (!best_found || (v_rdata.cost < best_rec.cost) ||
                       ((v_rdata.cost == best_rec.cost) &&
                        (v_rdata.stamp < best_rec.stamp)));

  assign cand_full = SUM_W'(best_rec.cost) + SUM_W'(e_rdata[WEIGHT_BITS-1:0]);
  assign cand      = (cand_full > SUM_W'(DIST_MAX_REACH)) ? DIST_MAX_REACH
                                                         : DIST_W'(cand_full);
  assign relax_ok  = pvalid && e_rdata[WEIGHT_BITS] && !v_rdata.visited &&
                     (pv != {1'b0, best_v}) && (cand < v_rdata.cost);

  assign out_hp = (v_rdata.cost != DIST_INF) && (v_rdata.pred != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.op)
            OP_CLEAR:     state_next = ST_CLEAR;
            OP_ADD_DIR:   state_next = ST_IDLE;
            OP_ADD_UNDIR: state_next = edge_ok ? ST_EDGE2 : ST_IDLE;
            OP_RUN:       state_next = ST_INIT;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_EDGE2: state_next = ST_IDLE;
      ST_INIT: begin
        if (idx == {1'b0, n_run}) state_next = src_ok ? ST_SEL : ST_OUT_RD;
      end
      ST_SEL: begin
        if (scan_done) state_next = best_found ? ST_MARK : ST_OUT_RD;
      end
      ST_MARK:  state_next = ST_RELAX;
      ST_RELAX: begin
        if (scan_done) state_next = ST_SEL;
      end
      ST_OUT_RD:   state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (!out_stall) state_next = (idx == {1'b0, n_run}) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    in_stall = (state != ST_IDLE);
    e_we     = 1'b0;
    e_waddr  = clr_cnt;
    e_wdata  = '0;
    e_raddr  = {VIDX_W'(best_v - VTX_W'(1)), VIDX_W'(idx - IDX_W'(1))};
    v_we     = 1'b0;
    v_waddr  = VIDX_W'(idx - IDX_W'(1));
    v_wdata  = '{cost: DIST_INF, pred: '0, visited: 1'b0, stamp: '0};
    v_raddr  = VIDX_W'(idx - IDX_W'(1));
    unique case (state)
      ST_CLEAR: e_we = 1'b1;
      ST_IDLE: begin
        e_we    = accept && edge_ok &&
                  ((in_item.op == OP_ADD_DIR) || (in_item.op == OP_ADD_UNDIR));
        e_waddr = {VIDX_W'(in_item.from_vertex - VTX_W'(1)),
                   VIDX_W'(in_item.to_vertex - VTX_W'(1))};
        e_wdata = {1'b1, w_in};
      end
      ST_EDGE2: begin
        e_we    = 1'b1;
        e_waddr = {VIDX_W'(item.to_vertex - VTX_W'(1)),
                   VIDX_W'(item.from_vertex - VTX_W'(1))};
        e_wdata = {1'b1, w_item};
      end
      ST_INIT: begin
        v_we = 1'b1;
        if (idx == {1'b0, item.from_vertex}) v_wdata.cost = '0;
      end
      ST_MARK: begin
        v_we            = 1'b1;
        v_waddr         = VIDX_W'(best_v - VTX_W'(1));
        v_wdata         = best_rec;
        v_wdata.visited = 1'b1;
      end
      ST_RELAX: begin
        v_we    = relax_ok;
        v_waddr = VIDX_W'(pv - IDX_W'(1));
        v_wdata = '{cost: cand, pred: best_v, visited: 1'b0, stamp: stamp_ctr};
      end
      ST_SEL, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      vertex_count <= VCOUNT_RESET;
      clr_cnt      <= '0;
      idx          <= IDX_W'(1);
      pvalid       <= 1'b0;
      best_found   <= 1'b0;
      stamp_ctr    <= '0;
      relax_cnt    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) vertex_count <= cfg_data;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + EADDR_W'(1);
        ST_IDLE: begin
          if (accept) begin
            item       <= in_item;
            n_run      <= n_act;
            idx        <= IDX_W'(1);
            clr_cnt    <= '0;
            stamp_ctr  <= STAMP_W'(1);
            relax_cnt  <= '0;
            best_found <= 1'b0;
          end
        end
        ST_EDGE2: begin
        end
        ST_INIT: begin
          idx <= (state_next != ST_INIT) ? IDX_W'(1) : idx + IDX_W'(1);
        end
        ST_SEL: begin
          pvalid <= issue;
          pv     <= idx;
          if (issue) idx <= idx + IDX_W'(1);
          if (pvalid && sel_better) begin
            best_found <= 1'b1;
            best_v     <= VTX_W'(pv);
            best_rec   <= v_rdata;
          end
          if (scan_done) idx <= IDX_W'(1);
        end
        ST_MARK: idx <= IDX_W'(1);
        ST_RELAX: begin
          pvalid <= issue;
          pv     <= idx;
          if (issue) idx <= idx + IDX_W'(1);
          if (relax_ok) begin
            stamp_ctr <= stamp_ctr + STAMP_W'(1);
            if (relax_cnt != COUNT_MAX) relax_cnt <= relax_cnt + CNT_W'(1);
          end
          if (scan_done) begin
            idx        <= IDX_W'(1);
            best_found <= 1'b0;
          end
        end
        ST_OUT_RD: begin
        end
        ST_OUT_WAIT: begin
          out_valid                <= 1'b1;
          out_item.vertex          <= VTX_W'(idx);
          out_item.distance        <= v_rdata.cost;
          out_item.has_predecessor <= out_hp;
          out_item.predecessor     <= out_hp ? v_rdata.pred : '0;
          out_item.relax_count     <= relax_cnt;
          out_item.last            <= (idx == {1'b0, n_run});
        end
        ST_OUT_HOLD: begin
          // hold the result until the transfer completes
          if (!out_stall) begin
            out_valid <= 1'b0;
            idx       <= idx + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/spe_path_checker.sv
`timescale 1ns / 1ps
// spe_path_checker: watches both channels of the shortest path engine and
// predicts every result from its own copy of the graph. Uses spe_pkg.
module spe_path_checker
  import spe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [VTX_W-1:0] cfg_data,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        run_count,
  output int        result_count
);

  localparam int NV = MAX_VERTICES_DEF;

  logic [VTX_W-1:0] vcount;
  bit               edge_on [1:NV][1:NV];
  logic [15:0]      edge_wt [1:NV][1:NV];
  out_item_t        path_results [$];

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic store_edge(input int a, input int b, input logic [15:0] w);
    edge_on[a][b] = 1'b1;
    edge_wt[a][b] = w;
  endtask

  // Settle least-distance vertices, ties to the earliest relaxation stamp.
  task automatic predict_paths(input int src);
    logic [DIST_W-1:0] vdist [1:NV];
    int               prev [1:NV];
    bit               done [1:NV];
    int               stamp [1:NV];
    int               n, stamp_next, relaxed, u, v;
    longint           cand;
    out_item_t        r;
    n = (vcount == 0) ? 1 : (vcount > NV) ? NV : int'(vcount);
    for (v = 1; v <= NV; v++) begin
      vdist[v] = DIST_INF;
      prev[v] = 0;
      done[v] = 0;
      stamp[v] = 0;
    end
    stamp_next = 0;
    relaxed = 0;
    if (src >= 1 && src <= n) begin
      vdist[src] = '0;
      stamp[src] = stamp_next++;
      forever begin
        u = 0;
        for (v = 1; v <= n; v++) begin
          if (done[v] || vdist[v] == DIST_INF) continue;
          if (u == 0 || vdist[v] < vdist[u] ||
              (vdist[v] == vdist[u] && stamp[v] < stamp[u]))
            u = v;
        end
        if (u == 0) break;
        done[u] = 1;
        for (v = 1; v <= n; v++) begin
          if (!edge_on[u][v] || done[v]) continue;
          cand = longint'(vdist[u]) + longint'(edge_wt[u][v]);
          if (cand > longint'(DIST_MAX_REACH)) cand = longint'(DIST_MAX_REACH);
          if (cand < longint'(vdist[v])) begin
            vdist[v] = cand[DIST_W-1:0];
            prev[v] = u;
            stamp[v] = stamp_next++;
            if (relaxed < int'(COUNT_MAX)) relaxed++;
          end
        end
      end
    end
    for (v = 1; v <= n; v++) begin
      r.vertex = v[VTX_W-1:0];
      r.distance = vdist[v];
      r.has_predecessor = (vdist[v] != DIST_INF) && (prev[v] != 0);
      r.predecessor = r.has_predecessor ? prev[v][VTX_W-1:0] : '0;
      r.relax_count = relaxed[CNT_W-1:0];
      r.last = (v == n);
      path_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int a, b;
    if (rst) begin
      vcount <= VCOUNT_RESET;
      foreach (edge_on[i, j]) edge_on[i][j] = 0;
      path_results.delete();
    end else begin
      if (cfg_write) vcount <= cfg_data;
      if (in_valid && !in_stall) begin
        a = int'(in_item.from_vertex);
        b = int'(in_item.to_vertex);
        case (op_e'(in_item.op))
          OP_CLEAR: foreach (edge_on[i, j]) edge_on[i][j] = 0;
          OP_ADD_DIR, OP_ADD_UNDIR: begin
            if (a >= 1 && a <= NV && b >= 1 && b <= NV) begin
              store_edge(a, b, in_item.edge_weight);
              if (op_e'(in_item.op) == OP_ADD_UNDIR) store_edge(b, a, in_item.edge_weight);
            end
          end
          default: begin
            run_count++;
            predict_paths(a);
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (path_results.size() == 0) begin
          report("unexpected result, vertex", int'(out_item.vertex), 0);
        end else begin
          want = path_results.pop_front();
          if (out_item.vertex != want.vertex)
            report("vertex", int'(out_item.vertex), int'(want.vertex));
          if (out_item.distance != want.distance)
            report("distance", int'(out_item.distance), int'(want.distance));
          if (out_item.has_predecessor != want.has_predecessor)
            report("has_predecessor", int'(out_item.has_predecessor),
                   int'(want.has_predecessor));
          if (out_item.predecessor != want.predecessor)
            report("predecessor", int'(out_item.predecessor), int'(want.predecessor));
          if (out_item.relax_count != want.relax_count)
            report("relax_count", int'(out_item.relax_count), int'(want.relax_count));
          if (out_item.last != want.last)
            report("last", int'(out_item.last), int'(want.last));
        end
      end
    end
    pending = path_results.size();
  end

endmodule

>>> sim/shortest_path_engine_unit_tb.sv
`timescale 1ns / 1ps
// shortest_path_engine_unit_tb: stimulus, idling and verdict for the shortest
// path engine. Depends on spe_pkg, shortest_path_engine_unit and spe_path_checker.
module shortest_path_engine_unit_tb;
  import spe_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [VTX_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  int               fail_count, pending, run_count, result_count;
  int               cyc;
  int               active_n;
  bit               held;

  shortest_path_engine_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  spe_path_checker u_check (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending),
    .run_count(run_count), .result_count(result_count)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit quiet_window();
    return cyc >= 30000 && cyc < 60000;
  endfunction

  // Receiver: random stalls outside the quiet window, plus one long hold once results start to flow.
  initial begin
    int hold_left;
    hold_left = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && out_valid && cyc > 1000) begin
        held = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  // Offer one item from a falling edge; hold it until the transfer.
  task automatic send(input op_e op, input int a, input int b, input logic [15:0] w);
    in_item_t it;
    it.op = op;
    it.from_vertex = a[VTX_W-1:0];
    it.to_vertex = b[VTX_W-1:0];
    it.edge_weight = w;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!quiet_window() && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic set_vertex_count(input int v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // allow a clear sweep still running after the last result
    repeat (4200) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v[VTX_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    active_n = (v == 0) ? 1 : (v > 64) ? 64 : v;
  endtask

  function automatic int pick_vertex();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, active_n);
    if (r < 93) return $urandom_range(1, 64);
    if (r < 96) return 0;
    return $urandom_range(65, 127);
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) send(OP_CLEAR, pick_vertex(), pick_vertex(), pick_weight());
      else if (r < 45) send(OP_ADD_DIR, pick_vertex(), pick_vertex(), pick_weight());
      else if (r < 88) send(OP_ADD_UNDIR, pick_vertex(), pick_vertex(), pick_weight());
      else send(OP_RUN, pick_vertex(), pick_vertex(), pick_weight());
    end
  endtask

  initial begin
    int sizes [8] = '{1, 5, 8, 16, 0, 127, 3, 100};
    int counts [8] = '{30, 70, 70, 70, 20, 40, 70, 40};
    cyc = 0;
    active_n = 64;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: ignored adds, self loop, overwrite, extreme weights, odd sources
    send(OP_ADD_DIR, 1, 2, 16'h0000);
    send(OP_ADD_UNDIR, 64, 63, 16'hFFFF);
    send(OP_ADD_DIR, 3, 3, 16'h0010);
    send(OP_ADD_DIR, 0, 4, 16'h0001);
    send(OP_ADD_DIR, 4, 127, 16'h0001);
    send(OP_ADD_UNDIR, 65, 5, 16'h0001);
    send(OP_ADD_DIR, 2, 64, 16'h1234);
    send(OP_ADD_DIR, 1, 2, 16'h0100);
    send(OP_ADD_DIR, 1, 3, 16'h0080);
    send(OP_ADD_DIR, 3, 2, 16'h0080);
    send(OP_RUN, 1, 0, 16'h0000);
    send(OP_RUN, 0, 127, 16'hFFFF);
    send(OP_RUN, 64, 1, 16'h0000);
    send(OP_RUN, 100, 0, 16'h0000);
    send(OP_CLEAR, 0, 0, 16'h0000);
    send(OP_RUN, 1, 0, 16'h0000);
    random_phase(30);

    foreach (sizes[k]) begin
      set_vertex_count(sizes[k]);
      random_phase(counts[k]);
    end
    set_vertex_count(64);
    random_phase(20);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d runs and %0d path results over nine vertex counts,",
             run_count, result_count);
    $display("with random stalls on both channels and one long output hold.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
